FILE: rtl/core/abd_pkg.sv
package abd_pkg;

  localparam int MAX_CLASSES_DEF = 128;
  localparam int MAX_GRID_DEF    = 128;
  localparam int ANCHORS_DEF     = 3;
  localparam int SIG_DEPTH_DEF   = 1024;

  localparam int FIFO_DEPTH = 2;
  // record fields sized for the largest grid and class parameters
  localparam int COL_W = 10;
  localparam int CLS_W = 10;

  localparam logic [63:0] ONE_Q32   = 64'h1_0000_0000;
  localparam logic [63:0] INV_E_Q32 = 64'd1580030169;

  typedef enum logic [3:0] {
    CFG_RAW_THR     = 4'd0,
    CFG_SCORE_THR   = 4'd1,
    CFG_GRID_W      = 4'd2,
    CFG_GRID_H      = 4'd3,
    CFG_STRIDE_LOG2 = 4'd4,
    CFG_CLASS_COUNT = 4'd5,
    CFG_ANCHOR_W    = 4'd6,
    CFG_ANCHOR_H    = 4'd7
  } cfg_index_e;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_LOOK,
    BK_SCORE,
    BK_WW,
    BK_HH,
    BK_WA,
    BK_HA,
    BK_BOX,
    BK_EMIT
  } back_state_e;

  typedef struct packed {
    logic signed [15:0] raw_thr;
    logic [15:0]        score_thr;
    logic [7:0]         grid_w;
    logic [7:0]         grid_h;
    logic [2:0]         stride_log2;
    logic [7:0]         class_count;
    logic [47:0]        anchor_w;
    logic [47:0]        anchor_h;
  } cfg_t;

  // logits: 0..3 box x/y/w/h, 4 objectness, 5 best class
  typedef struct packed {
    logic [5:0][15:0]   logits;
    logic [CLS_W-1:0]   cls_idx;
    logic [COL_W-1:0]   col;
    logic [COL_W-1:0]   row;
    logic [1:0]         anchor;
  } pred_t;

  // bit-serial long division, elaboration use only
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], n[i]};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(-n/256) in Q32 for n below 2560
  function automatic logic [63:0] exp_neg_q32(input logic [11:0] n);
    logic [63:0] sum;
    logic [63:0] term;
    logic [3:0]  k;
    logic [7:0]  f;
    k    = n[11:8];
    f    = n[7:0];
    sum  = ONE_Q32;
    term = ONE_Q32;
    for (int i = 1; i < 24; i++) begin
      term = udiv64(term * 64'(f), 64'(256 * i));
      if (i[0]) sum = sum - term;
      else      sum = sum + term;
    end
    for (int j = 0; j < 9; j++) begin
      if (4'(j) < k) sum = (sum * INV_E_Q32 + 64'h8000_0000) >> 32;
    end
    return sum;
  endfunction

  function automatic logic [15:0] sigmoid_entry(input int idx, input int depth);
    logic [63:0] d;
    logic [63:0] den;
    logic [63:0] s;
    logic [11:0] mag;
    int          xs;
    xs  = int'(udiv64(64'(idx) * 64'd4096, 64'(depth))) - 2048;
    mag = 12'(xs < 0 ? -xs : xs);
    d   = exp_neg_q32(mag);
    den = ONE_Q32 + d;
    if (xs >= 0) s = udiv64((64'd1 << 48) + (den >> 1), den);
    else         s = udiv64((d << 16) + (den >> 1), den);
    return (s > 64'd65535) ? 16'hFFFF : s[15:0];
  endfunction

endpackage

FILE: rtl/core/abd_front.sv
module abd_front #(
  parameter int MAX_CLASSES = abd_pkg::MAX_CLASSES_DEF,
  parameter int MAX_GRID    = abd_pkg::MAX_GRID_DEF,
  parameter int ANCHORS     = abd_pkg::ANCHORS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  abd_pkg::cfg_t      cfg_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] raw_value_i,
  input  logic               map_start_i,
  input  logic               full_i,
  output logic               push_o,
  output abd_pkg::pred_t     rec_o
);

  localparam int EW = $clog2(MAX_CLASSES + 5);
  localparam int CW = $clog2(MAX_GRID + 1);
  localparam int BW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;

  logic [EW-1:0]      elem_q, elem_d, e;
  logic [1:0]         anc_q, anc_d, a0;
  logic [CW-1:0]      col_q, col_d, c0;
  logic [CW-1:0]      row_q, row_d, r0;
  logic [3:0][15:0]   box_q, box_d;
  logic signed [15:0] obj_q, obj_d, best_q, best_d;
  logic [BW-1:0]      bidx_q, bidx_d;
  logic               rej_q, rej_d;

  logic [15:0] classes, gw, gh, last, e16, c_inc, r_inc;
  logic [2:0]  a_inc;
  logic        pred_end, accept;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;

  always_comb begin
    classes = (cfg_i.class_count == 8'd0) ? 16'd1 :
              (16'(cfg_i.class_count) > 16'(MAX_CLASSES)) ? 16'(MAX_CLASSES) :
              16'(cfg_i.class_count);
    gw = (cfg_i.grid_w == 8'd0) ? 16'd1 :
         (16'(cfg_i.grid_w) > 16'(MAX_GRID)) ? 16'(MAX_GRID) : 16'(cfg_i.grid_w);
    gh = (cfg_i.grid_h == 8'd0) ? 16'd1 :
         (16'(cfg_i.grid_h) > 16'(MAX_GRID)) ? 16'(MAX_GRID) : 16'(cfg_i.grid_h);
    last = 16'd4 + classes;

    e   = map_start_i ? '0 : elem_q;
    a0  = map_start_i ? '0 : anc_q;
    c0  = map_start_i ? '0 : col_q;
    r0  = map_start_i ? '0 : row_q;
    e16 = 16'(e);

    box_d  = box_q;
    obj_d  = obj_q;
    best_d = best_q;
    bidx_d = bidx_q;
    rej_d  = rej_q;
    if (e16 < 16'd4) begin
      box_d[e[1:0]] = raw_value_i;
    end else if (e16 == 16'd4) begin
      obj_d = raw_value_i;
      rej_d = raw_value_i < cfg_i.raw_thr;
    end else if (e16 == 16'd5) begin
      best_d = raw_value_i;
      bidx_d = '0;
    end else if (raw_value_i > best_q) begin
      best_d = raw_value_i;
      bidx_d = BW'(e16 - 16'd5);
    end

    pred_end = e16 >= last;
    elem_d   = pred_end ? '0 : EW'(e16 + 16'd1);

    a_inc = {1'b0, a0} + 3'd1;
    c_inc = 16'(c0) + 16'd1;
    r_inc = 16'(r0) + 16'd1;
    anc_d = a0;
    col_d = c0;
    row_d = r0;
    if (pred_end) begin
      if (a_inc >= 3'(ANCHORS)) begin
        anc_d = '0;
        if (c_inc >= gw) begin
          col_d = '0;
          row_d = (r_inc >= gh) ? '0 : CW'(r_inc);
        end else begin
          col_d = CW'(c_inc);
        end
      end else begin
        anc_d = a_inc[1:0];
        if (16'(c0) >= gw) col_d = '0;
        if (16'(r0) >= gh) row_d = '0;
      end
    end
  end

  always_comb begin
    rec_o.logits[0] = box_d[0];
    rec_o.logits[1] = box_d[1];
    rec_o.logits[2] = box_d[2];
    rec_o.logits[3] = box_d[3];
    rec_o.logits[4] = obj_d;
    rec_o.logits[5] = best_d;
    rec_o.cls_idx   = abd_pkg::CLS_W'(bidx_d);
    rec_o.col       = abd_pkg::COL_W'(c0);
    rec_o.row       = abd_pkg::COL_W'(r0);
    rec_o.anchor    = a0;
  end

  assign push_o = accept && pred_end && !rej_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elem_q <= '0;
      anc_q  <= '0;
      col_q  <= '0;
      row_q  <= '0;
      box_q  <= '0;
      obj_q  <= '0;
      best_q <= '0;
      bidx_q <= '0;
      rej_q  <= 1'b0;
    end else if (accept) begin
      elem_q <= elem_d;
      anc_q  <= anc_d;
      col_q  <= col_d;
      row_q  <= row_d;
      box_q  <= box_d;
      obj_q  <= obj_d;
      best_q <= best_d;
      bidx_q <= bidx_d;
      rej_q  <= rej_d;
    end
  end

endmodule

FILE: rtl/core/abd_fifo.sv
module abd_fifo #(
  parameter int DEPTH = abd_pkg::FIFO_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  abd_pkg::pred_t data_i,
  input  logic           pop_i,
  output abd_pkg::pred_t data_o,
  output logic           full_o,
  output logic           empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  abd_pkg::pred_t    mem_q [DEPTH];
  logic [PW-1:0]     wr_q, rd_q;
  logic [NW-1:0]     cnt_q;

  assign full_o  = cnt_q == NW'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
      if (pop_i)  rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
      if (push_i && !pop_i)      cnt_q <= cnt_q + NW'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o || pop_i) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("queue pop while empty");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= NW'(DEPTH)) else $error("queue count out of range");

endmodule

FILE: rtl/core/abd_back.sv
module abd_back #(
  parameter int SIG_DEPTH = abd_pkg::SIG_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  abd_pkg::cfg_t      cfg_i,
  input  abd_pkg::pred_t     rec_i,
  input  logic               empty_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [6:0]         class_id_o,
  output logic [15:0]        score_o,
  output logic signed [15:0] box_x_o,
  output logic signed [15:0] box_y_o,
  output logic [14:0]        box_w_o,
  output logic [14:0]        box_h_o,
  output logic [6:0]         cell_col_o,
  output logic [6:0]         cell_row_o
);

  localparam int IW = $clog2(SIG_DEPTH);

  typedef logic [15:0] rom_t [SIG_DEPTH];

  function automatic rom_t build_rom();
    rom_t r;
    for (int i = 0; i < SIG_DEPTH; i++) r[i] = abd_pkg::sigmoid_entry(i, SIG_DEPTH);
    return r;
  endfunction

  localparam rom_t SIG_ROM = build_rom();

  abd_pkg::back_state_e state_q, state_d;
  abd_pkg::pred_t       rec_q;
  logic [2:0]           k_q;
  logic [5:0][15:0]     sig_q;
  logic [15:0]          rom_q;
  logic [15:0]          score_q;
  logic [33:0]          ww_q, hh_q;
  logic [49:0]          w32_q, h32_q;
  logic signed [15:0]   res_x_q, res_y_q;
  logic [14:0]          res_w_q, res_h_q;
  logic                 out_valid_q, out_free, load_out;

  // lookup address
  logic [2:0]         k_sel;
  logic signed [15:0] lx;
  logic [11:0]        lu;
  logic [24:0]        lprod;
  logic [IW-1:0]      addr;

  always_comb begin
    k_sel = (k_q < 3'd6) ? k_q : 3'd0;
    lx    = $signed(rec_q.logits[k_sel]);
    if (lx < -16'sd2048)     lu = 12'd0;
    else if (lx > 16'sd2047) lu = 12'd4095;
    else                     lu = 12'(lx + 16'sd2048);
    lprod = 25'(lu) * 25'(SIG_DEPTH);
    addr  = lprod[12 +: IW];
  end

  always_ff @(posedge clk_i) begin
    rom_q <= SIG_ROM[addr];
  end

  // shared multiplier
  logic [33:0] mul_a;
  logic [16:0] mul_b;
  logic [50:0] mul_p;
  logic [16:0] tw, th;
  logic [15:0] aw, ah, score_c;
  logic [32:0] score_sum;

  assign tw = {sig_q[2], 1'b0};
  assign th = {sig_q[3], 1'b0};

  always_comb begin
    case (rec_q.anchor)
      2'd0:    begin aw = cfg_i.anchor_w[15:0];  ah = cfg_i.anchor_h[15:0];  end
      2'd1:    begin aw = cfg_i.anchor_w[31:16]; ah = cfg_i.anchor_h[31:16]; end
      2'd2:    begin aw = cfg_i.anchor_w[47:32]; ah = cfg_i.anchor_h[47:32]; end
      default: begin aw = '0;                    ah = '0;                    end
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      abd_pkg::BK_SCORE: begin mul_a = 34'(sig_q[4]); mul_b = 17'(sig_q[5]); end
      abd_pkg::BK_WW:    begin mul_a = 34'(tw);       mul_b = tw;            end
      abd_pkg::BK_HH:    begin mul_a = 34'(th);       mul_b = th;            end
      abd_pkg::BK_WA:    begin mul_a = ww_q;          mul_b = 17'(aw);       end
      abd_pkg::BK_HA:    begin mul_a = hh_q;          mul_b = 17'(ah);       end
      default:           begin mul_a = '0;            mul_b = '0;            end
    endcase
    mul_p = 51'(mul_a) * 51'(mul_b);
  end

  assign score_sum = mul_p[32:0] + 33'd32768;
  assign score_c   = score_sum[31:16];

  // box edges: Q32 pixels, rounded to Q12.4
  logic signed [27:0] tx, ty;
  logic signed [53:0] cx, cy, vx, vy, qx, qy;
  logic [50:0]        vw, vh;
  logic [4:0]         shamt;

  always_comb begin
    shamt = 5'd16 + 5'(cfg_i.stride_log2);
    tx = $signed(28'({sig_q[0], 1'b0})) - 28'sd32768 + $signed(28'({rec_q.col, 16'b0}));
    ty = $signed(28'({sig_q[1], 1'b0})) - 28'sd32768 + $signed(28'({rec_q.row, 16'b0}));
    cx = 54'(tx) <<< shamt;
    cy = 54'(ty) <<< shamt;
    vx = cx - $signed(54'(w32_q >> 1)) + 54'sd134217728;
    vy = cy - $signed(54'(h32_q >> 1)) + 54'sd134217728;
    qx = vx >>> 28;
    qy = vy >>> 28;
    vw = (51'(w32_q) + 51'd134217728) >> 28;
    vh = (51'(h32_q) + 51'd134217728) >> 28;
  end

  function automatic logic signed [15:0] sat16(input logic signed [53:0] v);
    if (v < -54'sd32768)     return 16'sh8000;
    else if (v > 54'sd32767) return 16'sh7FFF;
    else                     return v[15:0];
  endfunction

  function automatic logic [14:0] sat15(input logic [50:0] v);
    return (v > 51'd32767) ? 15'h7FFF : v[14:0];
  endfunction

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      abd_pkg::BK_IDLE:  if (!empty_i) state_d = abd_pkg::BK_LOOK;
      abd_pkg::BK_LOOK:  if (k_q == 3'd6) state_d = abd_pkg::BK_SCORE;
      abd_pkg::BK_SCORE: state_d = (score_c >= cfg_i.score_thr) ? abd_pkg::BK_WW :
                                                                  abd_pkg::BK_IDLE;
      abd_pkg::BK_WW:    state_d = abd_pkg::BK_HH;
      abd_pkg::BK_HH:    state_d = abd_pkg::BK_WA;
      abd_pkg::BK_WA:    state_d = abd_pkg::BK_HA;
      abd_pkg::BK_HA:    state_d = abd_pkg::BK_BOX;
      abd_pkg::BK_BOX:   state_d = abd_pkg::BK_EMIT;
      abd_pkg::BK_EMIT:  if (out_free) state_d = abd_pkg::BK_IDLE;
      default:           state_d = abd_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    pop_o    = (state_q == abd_pkg::BK_IDLE) && !empty_i;
    load_out = (state_q == abd_pkg::BK_EMIT) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= abd_pkg::BK_IDLE;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop_o)                          k_q <= '0;
      else if (state_q == abd_pkg::BK_LOOK) k_q <= k_q + 3'd1;
      if (load_out)         out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) rec_q <= rec_i;
    // ROM data is registered, so it lands in the cycle after its address
    if (state_q == abd_pkg::BK_LOOK && k_q != 3'd0) sig_q[k_q - 3'd1] <= rom_q;
    if (state_q == abd_pkg::BK_SCORE) score_q <= score_c;
    if (state_q == abd_pkg::BK_WW)    ww_q    <= mul_p[33:0];
    if (state_q == abd_pkg::BK_HH)    hh_q    <= mul_p[33:0];
    if (state_q == abd_pkg::BK_WA)    w32_q   <= mul_p[49:0];
    if (state_q == abd_pkg::BK_HA)    h32_q   <= mul_p[49:0];
    if (state_q == abd_pkg::BK_BOX) begin
      res_x_q <= sat16(qx);
      res_y_q <= sat16(qy);
      res_w_q <= sat15(vw);
      res_h_q <= sat15(vh);
    end
    if (load_out) begin
      class_id_o <= rec_q.cls_idx[6:0];
      score_o    <= score_q;
      box_x_o    <= res_x_q;
      box_y_o    <= res_y_q;
      box_w_o    <= res_w_q;
      box_h_o    <= res_h_q;
      cell_col_o <= rec_q.col[6:0];
      cell_row_o <= rec_q.row[6:0];
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/core/anchor_box_decode_core.sv
// Channel   Direction  Handshake                  Payload
// in        input      in_valid_i / in_stall_o    raw_value_i, map_start_i
// out       output     out_valid_o / out_stall_i  class_id, score, box_x/y/w/h, cell_col/row
// cfg       input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// The front takes one element per cycle; it stalls only while the two-entry
// prediction queue is full. The back handles one prediction at a time: it pops it, makes
// six sigmoid ROM lookups (one registered read port) and a score step, and stops there
// for a prediction below the score threshold. A detection goes on through the shared
// multiplier steps, a box step and an output step, held longer while the output stalls.
// A prediction is at least six elements, so a stream of short predictions stalls the
// input; with many classes the queue hides the back. Reset is asynchronous active low;
// no clearing pass.
module anchor_box_decode_core #(
  parameter int MAX_CLASSES = abd_pkg::MAX_CLASSES_DEF,
  parameter int MAX_GRID    = abd_pkg::MAX_GRID_DEF,
  parameter int ANCHORS     = abd_pkg::ANCHORS_DEF,
  parameter int SIG_DEPTH   = abd_pkg::SIG_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [3:0]         cfg_index_i,
  input  logic [47:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] raw_value_i,
  input  logic               map_start_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [6:0]         class_id_o,
  output logic [15:0]        score_o,
  output logic signed [15:0] box_x_o,
  output logic signed [15:0] box_y_o,
  output logic [14:0]        box_w_o,
  output logic [14:0]        box_h_o,
  output logic [6:0]         cell_col_o,
  output logic [6:0]         cell_row_o
);

  abd_pkg::cfg_t  cfg_q;
  abd_pkg::pred_t push_rec, head_rec;
  logic           push, pop, full, empty;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.raw_thr     <= 16'sd0;
      cfg_q.score_thr   <= 16'd32768;
      cfg_q.grid_w      <= 8'd80;
      cfg_q.grid_h      <= 8'd80;
      cfg_q.stride_log2 <= 3'd3;
      cfg_q.class_count <= 8'd80;
      cfg_q.anchor_w    <= '0;
      cfg_q.anchor_h    <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        abd_pkg::CFG_RAW_THR:     cfg_q.raw_thr     <= cfg_data_i[15:0];
        abd_pkg::CFG_SCORE_THR:   cfg_q.score_thr   <= cfg_data_i[15:0];
        abd_pkg::CFG_GRID_W:      cfg_q.grid_w      <= cfg_data_i[7:0];
        abd_pkg::CFG_GRID_H:      cfg_q.grid_h      <= cfg_data_i[7:0];
        abd_pkg::CFG_STRIDE_LOG2: cfg_q.stride_log2 <= cfg_data_i[2:0];
        abd_pkg::CFG_CLASS_COUNT: cfg_q.class_count <= cfg_data_i[7:0];
        abd_pkg::CFG_ANCHOR_W:    cfg_q.anchor_w    <= cfg_data_i;
        abd_pkg::CFG_ANCHOR_H:    cfg_q.anchor_h    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  abd_front #(
    .MAX_CLASSES(MAX_CLASSES),
    .MAX_GRID   (MAX_GRID),
    .ANCHORS    (ANCHORS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .raw_value_i(raw_value_i),
    .map_start_i(map_start_i),
    .full_i     (full),
    .push_o     (push),
    .rec_o      (push_rec)
  );

  abd_fifo #(
    .DEPTH(abd_pkg::FIFO_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_rec),
    .pop_i  (pop),
    .data_o (head_rec),
    .full_o (full),
    .empty_o(empty)
  );

  abd_back #(
    .SIG_DEPTH(SIG_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .rec_i      (head_rec),
    .empty_i    (empty),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .class_id_o (class_id_o),
    .score_o    (score_o),
    .box_x_o    (box_x_o),
    .box_y_o    (box_y_o),
    .box_w_o    (box_w_o),
    .box_h_o    (box_h_o),
    .cell_col_o (cell_col_o),
    .cell_row_o (cell_row_o)
  );

endmodule
